@@ sv/float_precision_converter_defines.svh @@
// Assertion macros for the precision converter
`ifndef FLOAT_PRECISION_CONVERTER_DEFINES_SVH
`define FLOAT_PRECISION_CONVERTER_DEFINES_SVH
// assert an implication at each clock edge outside reset
`define FPC_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// assert a condition in the cycle after another holds
`define FPC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

@@ sv/fpc_pkg.sv @@
// Package with opcodes, types and conversion helpers for the precision converter
package fpc_pkg;
   localparam int unsigned CmdWidth = 3;
   localparam int unsigned DataWidth = 32;
   localparam int unsigned TdataWidth = 40;

   typedef enum logic [CmdWidth-1:0] {
      CMD_F32_BF16 = 3'd0,
      CMD_BF16_F32 = 3'd1,
      CMD_F32_F16  = 3'd2,
      CMD_F16_F32  = 3'd3,
      CMD_F32_I8   = 3'd4,
      CMD_F16_I8   = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [CmdWidth-1:0]  cmd;
      logic [DataWidth-1:0] bits;
   } stage_type;

   function automatic logic [31:0] f32_to_f16(input logic [31:0] x);
      logic signed [9:0] e;
      logic [15:0] r;
      e = $signed({2'b00, x[30:23]}) - 10'sd112;
      if (e <= 10'sd0) r = {x[31], 15'd0};
      else if (e >= 10'sd31) r = {x[31], 15'h7C00};
      else r = {x[31], e[4:0], x[22:13]};
      return {16'd0, r};
   endfunction

   function automatic logic [3:0] lead_shift(input logic [9:0] m);
      logic [3:0] s;
      s = 4'd10;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) s = 4'(10 - i);
      end
      return s;
   endfunction

   function automatic logic [31:0] f16_to_f32(input logic [15:0] h);
      logic [4:0] e;
      logic [9:0] m;
      logic [3:0] s;
      logic [10:0] sm;
      logic [7:0] oe;
      logic [9:0] om;
      e = h[14:10];
      m = h[9:0];
      s = lead_shift(m);
      sm = {1'b0, m} << s;
      if (e == 5'h1F) begin
         oe = 8'hFF;
         om = m;
      end else if (e == 5'd0) begin
         if (m == 10'd0) begin
            oe = 8'd0;
            om = 10'd0;
         end else begin
            oe = 8'd113 - {4'd0, s};
            om = sm[9:0];
         end
      end else begin
         oe = {3'd0, e} + 8'd112;
         om = m;
      end
      return {h[15], oe, om, 13'd0};
   endfunction

   function automatic logic [31:0] f32_to_i8(input logic [31:0] x);
      logic [7:0] e;
      logic [23:0] m;
      logic [4:0] sh;
      logic [24:0] sum;
      logic [8:0] mag;
      logic [7:0] r;
      e = x[30:23];
      m = {1'b1, x[22:0]};
      sh = 5'(8'd150 - e);
      sum = {1'b0, m} + (25'd1 << (sh - 5'd1));
      if (e < 8'd126) mag = 9'd0;
      else if (e >= 8'd135) mag = 9'd256;
      else mag = 9'(sum >> sh);
      if (x[31]) r = (mag >= 9'd128) ? 8'h80 : 8'(9'd0 - mag);
      else r = (mag > 9'd127) ? 8'd127 : mag[7:0];
      if (e == 8'hFF && x[22:0] != 23'd0) r = 8'd0;
      return {24'd0, r};
   endfunction
endpackage

@@ sv/float_precision_converter.sv @@
// Three-stage streaming converter between fp32, bf16, fp16 and int8 formats
// One item enters per cycle unless stalled: stage one registers the item, stage two adds its
// fp16 source widened to fp32, stage three selects and holds the fp32 narrowing, int8 rounding
// or bf16 result. Backpressure stalls all stages together; nothing is dropped or repeated.
`include "float_precision_converter_defines.svh"
module float_precision_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [fpc_pkg::TdataWidth-1:0] req_tdata,  // cmd[2:0], operand_bits[34:3], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // result_bits[31:0]
);
   logic             adv;
   logic [2:0]       vld_ff, vld_in;
   fpc_pkg::stage_type s1_ff, s1_in, s2_ff, s2_in;
   logic [31:0]      wide_ff, wide_in, s3_ff, s3_in;

   assign adv = !vld_ff[2] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[2];
   assign rsp_tdata = s3_ff;

   always_comb begin
      vld_in = {vld_ff[1:0], req_tvalid};
      s1_in.cmd = req_tdata[2:0];
      s1_in.bits = req_tdata[34:3];
      wide_in = fpc_pkg::f16_to_f32(s1_ff.bits[15:0]);
      s2_in.cmd = s1_ff.cmd;
      s2_in.bits = s1_ff.bits;
      case (s2_ff.cmd)
         fpc_pkg::CMD_F32_BF16: s3_in = {16'd0, s2_ff.bits[31:16]};
         fpc_pkg::CMD_BF16_F32: s3_in = {s2_ff.bits[15:0], 16'd0};
         fpc_pkg::CMD_F32_F16:  s3_in = fpc_pkg::f32_to_f16(s2_ff.bits);
         fpc_pkg::CMD_F16_F32:  s3_in = wide_ff;
         fpc_pkg::CMD_F32_I8:   s3_in = fpc_pkg::f32_to_i8(s2_ff.bits);
         fpc_pkg::CMD_F16_I8:   s3_in = fpc_pkg::f32_to_i8(wide_ff);
         default:               s3_in = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         wide_ff <= wide_in;
         s3_ff <= s3_in;
      end
   end

   `FPC_ASSERT_IMPL(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready, !req_tready, "stall")
   `FPC_ASSERT_NEXT(a_hold_out, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "hold")
   `FPC_ASSERT_NEXT(a_flow, clock, reset, req_tvalid && req_tready, vld_ff[0], "flow")
endmodule

@@ verif/float_precision_converter_tb.sv @@
// Stream testbench for the precision converter: random and directed items, predicted results
module float_precision_converter_tb;
   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] bits;
   } conv_item_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   conv_item_type pending_items[$];
   logic [31:0] expected_bits[$];
   int          mismatch_count;
   int          cycle_count;
   int          send_gap;
   int          recv_gap;
   bit          stimulus_done;
   bit          req_taken;

   float_precision_converter dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic logic [31:0] widen_half(input logic [15:0] h);
      logic [4:0]  e;
      logic [10:0] m;
      logic [7:0]  oe;
      int          s;
      e = h[14:10];
      m = {1'b0, h[9:0]};
      s = 0;
      if (e == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
      if (e != 5'd0) return {h[15], 8'(e + 8'd112), h[9:0], 13'd0};
      if (m == 11'd0) return {h[15], 31'd0};
      while (!m[10] && s < 11) begin
         m = m << 1;
         s++;
      end
      oe = 8'(113 - s);
      return {h[15], oe, m[9:0], 13'd0};
   endfunction

   function automatic logic [31:0] narrow_half(input logic [31:0] x);
      int e;
      e = int'(x[30:23]) - 112;
      if (e <= 0) return {16'd0, x[31], 15'd0};
      if (e >= 31) return {16'd0, x[31], 15'h7C00};
      return {16'd0, x[31], 5'(e), x[22:13]};
   endfunction

   function automatic logic [31:0] round_to_byte(input logic [31:0] x);
      int unsigned e;
      longint unsigned m;
      longint unsigned mag;
      int unsigned sh;
      e = x[30:23];
      if (e == 255 && x[22:0] != 0) return 32'd0;
      if (e < 126) mag = 0;
      else if (e >= 135) mag = 256;
      else begin
         m = {1'b1, x[22:0]};
         sh = 150 - e;
         mag = (m + (64'd1 << (sh - 1))) >> sh;
      end
      if (x[31]) return (mag >= 128) ? 32'h80 : {24'd0, 8'(0 - mag)};
      return (mag > 127) ? 32'd127 : 32'(mag);
   endfunction

   function automatic logic [31:0] convert_bits(input conv_item_type it);
      case (it.cmd)
         fpc_pkg::CMD_F32_BF16: return {16'd0, it.bits[31:16]};
         fpc_pkg::CMD_BF16_F32: return {it.bits[15:0], 16'd0};
         fpc_pkg::CMD_F32_F16:  return narrow_half(it.bits);
         fpc_pkg::CMD_F16_F32:  return widen_half(it.bits[15:0]);
         fpc_pkg::CMD_F32_I8:   return round_to_byte(it.bits);
         fpc_pkg::CMD_F16_I8:   return round_to_byte(widen_half(it.bits[15:0]));
         default:               return 32'd0;
      endcase
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic logic [31:0] random_bits(input logic [2:0] cmd);
      logic [31:0] v;
      v = $urandom;
      if (cmd == fpc_pkg::CMD_F32_I8 && $urandom_range(0, 2) != 0)
         v[30:23] = 8'($urandom_range(120, 140));
      if (cmd == fpc_pkg::CMD_F16_I8 && $urandom_range(0, 2) != 0)
         v[14:10] = 5'($urandom_range(12, 23));
      if (cmd == fpc_pkg::CMD_F32_F16 && $urandom_range(0, 2) != 0)
         v[30:23] = 8'($urandom_range(108, 146));
      if ((cmd == fpc_pkg::CMD_F16_F32 || cmd == fpc_pkg::CMD_F16_I8) &&
          $urandom_range(0, 5) == 0)
         v[14:10] = 5'd0;
      return v;
   endfunction

   initial begin
      conv_item_type it;
      logic [31:0] directed[$];
      directed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7FC0_0001, 32'h0000_0001, 32'h3F00_0000, 32'hBFC0_0000, 32'h42FE_0000,
                   32'hC300_0000, 32'h4300_0000, 32'h3880_0000, 32'h4780_0000, 32'h0000_0200,
                   32'h0000_8001, 32'h0000_7C01, 32'h0000_5BF0, 32'h0000_D800};
      foreach (directed[i]) begin
         for (int c = 0; c < 8; c++) begin
            if (i < 6 || c < 6) begin
               it.cmd = 3'(c);
               it.bits = directed[i];
               pending_items.push_back(it);
            end
         end
      end
      for (int n = 0; n < 624; n++) begin
         it.cmd = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
         it.bits = random_bits(it.cmd);
         pending_items.push_back(it);
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // driver: present at falling edge, pop on acceptance
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            expected_bits.push_back(convert_bits(pending_items.pop_front()));
            send_gap = pick_gap();
         end
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= {5'd0, pending_items[0].bits, pending_items[0].cmd};
         end else begin
            req_tvalid <= 1'b0;
            stimulus_done = 1'b1;
         end
         if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap = pick_gap();
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [31:0] want;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            want = expected_bits.pop_front();
            if (rsp_tdata !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result_bits mismatch: expected %h actual %h", want, rsp_tdata);
            end
         end
      end
   end

   initial begin
      mismatch_count = 0;
      cycle_count = 0;
      send_gap = 0;
      recv_gap = 0;
      stimulus_done = 1'b0;
      while (!(stimulus_done && expected_bits.size() == 0) && cycle_count < 200000) begin
         @(posedge clock);
         cycle_count++;
      end
      if (cycle_count >= 200000) begin
         $display("float_precision_converter test failed");
         $finish;
      end else begin
         repeat (10) @(posedge clock);
         if (mismatch_count == 0) begin
            $display("float_precision_converter test passed");
         end else begin
            $display("float_precision_converter test failed");
         end
         $finish;
      end
   end
endmodule

@@ filelist.f @@
+incdir+sv
sv/fpc_pkg.sv
sv/float_precision_converter.sv
verif/float_precision_converter_tb.sv
